FILE: rtl/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg
// Shared constants and types for the sliding-window pattern replace stream.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

  // Longest pattern the window can hold.
  localparam int MAX_PATTERN = 8;

  localparam int BYTE_W    = 8;
  localparam int PAT_W     = 64;
  localparam int PLEN_W    = 4;
  localparam int CFG_IDX_W = 2;
  // Holds 0..MAX_PATTERN results or pending bytes.
  localparam int CNT_W     = $clog2(MAX_PATTERN + 1);
  // Addresses one window entry.
  localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN = 2'd0,
    REG_LENGTH  = 2'd1,
    REG_REPLACE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              rep;
  } entry_t;

  // All results that one input byte causes, oldest in entry 0.
  typedef struct packed {
    entry_t [MAX_PATTERN-1:0] entries;
    logic   [CNT_W-1:0]       count;
    logic                     last;
  } burst_t;

endpackage

`default_nettype wire

FILE: rtl/prs_window.sv
// ----------------------------------------------------------------------------
// prs_window
// Configuration registers, pending-byte window and the per-byte match step.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_window (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [prs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [prs_pkg::PAT_W-1:0]          cfg_data,
  input  wire logic                               in_take,
  input  wire logic [prs_pkg::BYTE_W-1:0]         in_byte,
  input  wire logic                               end_of_stream,
  output prs_pkg::burst_t                         step
);

  logic [prs_pkg::PAT_W-1:0]   pattern;
  logic [prs_pkg::PLEN_W-1:0]  plen;
  logic [prs_pkg::BYTE_W-1:0]  rep_byte;
  logic [prs_pkg::MAX_PATTERN-1:0][prs_pkg::BYTE_W-1:0] window;
  logic [prs_pkg::MAX_PATTERN-1:0][prs_pkg::BYTE_W-1:0] window_next;
  logic [prs_pkg::WIN_IDX_W-1:0] fill;
  logic [prs_pkg::WIN_IDX_W-1:0] fill_next;

  logic [prs_pkg::CNT_W-1:0] len;
  logic [prs_pkg::CNT_W-1:0] f1;
  logic [prs_pkg::MAX_PATTERN-1:0][prs_pkg::BYTE_W-1:0] wtmp;
  logic full;
  logic match;

  always_comb begin
    if (plen == '0) begin
      len = prs_pkg::CNT_W'(1);
    end else if (plen > prs_pkg::PLEN_W'(prs_pkg::MAX_PATTERN)) begin
      len = prs_pkg::CNT_W'(prs_pkg::MAX_PATTERN);
    end else begin
      len = prs_pkg::CNT_W'(plen);
    end

    wtmp       = window;
    wtmp[fill] = in_byte;
    f1         = prs_pkg::CNT_W'(fill) + prs_pkg::CNT_W'(1);
    full       = (f1 == len);

    match = 1'b1;
    for (int i = 0; i < prs_pkg::MAX_PATTERN; i++) begin
      if ((prs_pkg::CNT_W'(i) < len) &&
          (wtmp[i] != pattern[prs_pkg::BYTE_W*i +: prs_pkg::BYTE_W])) begin
        match = 1'b0;
      end
    end

    // With a full window entry 0 is the step's own result and the rest are
    // the bytes left after the shift, which a flush emits in place.
    for (int k = 0; k < prs_pkg::MAX_PATTERN; k++) begin
      step.entries[k].data = wtmp[k];
      step.entries[k].rep  = 1'b0;
    end
    if (full && match) begin
      step.entries[0].data = rep_byte;
      step.entries[0].rep  = 1'b1;
    end

    if (end_of_stream) begin
      if (full) begin
        step.count = match ? prs_pkg::CNT_W'(1) : len;
      end else begin
        step.count = f1;
      end
    end else begin
      step.count = full ? prs_pkg::CNT_W'(1) : '0;
    end
    step.last = end_of_stream;

    window_next = wtmp;
    if (full && !match) begin
      for (int i = 0; i < prs_pkg::MAX_PATTERN - 1; i++) begin
        window_next[i] = wtmp[i+1];
      end
    end

    if (end_of_stream) begin
      fill_next = '0;
    end else if (full) begin
      fill_next = match ? '0 : prs_pkg::WIN_IDX_W'(len - prs_pkg::CNT_W'(1));
    end else begin
      fill_next = prs_pkg::WIN_IDX_W'(f1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern  <= '0;
      plen     <= prs_pkg::PLEN_W'(1);
      rep_byte <= '0;
      fill     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        prs_pkg::REG_PATTERN: pattern <= cfg_data;
        prs_pkg::REG_LENGTH: begin
          // A new length drops whatever is pending.
          plen <= cfg_data[prs_pkg::PLEN_W-1:0];
          fill <= '0;
        end
        prs_pkg::REG_REPLACE: rep_byte <= cfg_data[prs_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end else if (in_take) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      window <= window_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/prs_out.sv
// ----------------------------------------------------------------------------
// prs_out
// Result buffer for one byte's results and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_out (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire prs_pkg::burst_t            step,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  output logic                            in_take,
  output logic [prs_pkg::BYTE_W-1:0]      out_byte,
  output logic                            is_replacement,
  output logic                            last_out,
  output logic                            out_valid,
  input  wire logic                       out_stall
);

  prs_pkg::entry_t [prs_pkg::MAX_PATTERN-1:0] entries;
  logic [prs_pkg::CNT_W-1:0]                  count;
  logic                                       burst_last;
  logic                                       move;

  assign move     = (count != '0) && (!out_valid || !out_stall);
  // A new byte is taken once the buffer is empty or empties in this cycle.
  assign in_stall = !((count == '0) || ((count == prs_pkg::CNT_W'(1)) && move));
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_take) begin
      count <= step.count;
    end else if (move) begin
      count <= count - prs_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      entries    <= step.entries;
      burst_last <= step.last;
    end else if (move) begin
      for (int i = 0; i < prs_pkg::MAX_PATTERN - 1; i++) begin
        entries[i] <= entries[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte       <= entries[0].data;
      is_replacement <= entries[0].rep;
      last_out       <= burst_last && (count == prs_pkg::CNT_W'(1));
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= prs_pkg::CNT_W'(prs_pkg::MAX_PATTERN))
    else $error("result buffer count out of range");

  a_move_shows: assert property (@(posedge clk) disable iff (rst)
    move |=> out_valid)
    else $error("result moved but output not valid");

  a_rise_from_buf: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(count) != '0)
    else $error("output valid without a buffered result");

  a_take_empties: assert property (@(posedge clk) disable iff (rst)
    (in_take && step.count == '0 && !move) |=> count == '0)
    else $error("buffer not empty after a byte with no result");

endmodule

`default_nettype wire

FILE: rtl/pattern_replace_stream.sv
// ----------------------------------------------------------------------------
// pattern_replace_stream
// Sliding-window byte pattern replacement with end-of-stream flush.
// ----------------------------------------------------------------------------
// Channel  Signals                               Direction  Transfer when
// in       in_valid, in_stall, in_byte, eos      in         valid && !stall
// out      out_valid, out_stall, out_byte, ...   out        valid && !stall
// cfg      cfg_valid, cfg_ready, index, data     in         valid && ready
//
// One byte per cycle in a steady, unstalled stream; a result goes through the
// result buffer, then the output register. A byte with end_of_stream flushes
// up to 8 results, one per unstalled cycle out of the result buffer, and input
// is held meanwhile. Input stall follows result buffer occupancy and output stall.
// Synchronous reset restores the register defaults and empties the window and
// the buffer; the configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pattern_replace_stream (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [prs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [prs_pkg::PAT_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [prs_pkg::BYTE_W-1:0]    in_byte,
  input  wire logic                          end_of_stream,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [prs_pkg::BYTE_W-1:0]         out_byte,
  output logic                               is_replacement,
  output logic                               last_out
);

  prs_pkg::burst_t step;
  logic            in_take;

  assign cfg_ready = 1'b1;

  prs_window u_window (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_take       (in_take),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .step          (step)
  );

  prs_out u_out (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_take        (in_take),
    .out_byte       (out_byte),
    .is_replacement (is_replacement),
    .last_out       (last_out),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

endmodule

`default_nettype wire

FILE: dv/pattern_replace_stream_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pattern_replace_stream_tb
// Self-checking testbench for the sliding-window pattern replace stream. A
// software copy of the window predicts every output byte, and each output
// transfer is checked against the oldest prediction. Directed streams cover
// the register extremes, zero bytes in the pattern, the longest flush and a
// length write that drops pending bytes. Random streams then run under random
// idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module pattern_replace_stream_tb;

  localparam int LIMIT_CYCLES   = 400000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RX_HOLD_CYCLES = 200;

  typedef struct {
    logic [prs_pkg::BYTE_W-1:0] data;
    logic                       rep;
    logic                       last;
  } result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [prs_pkg::CFG_IDX_W-1:0] cfg_index = prs_pkg::REG_PATTERN;
  logic [prs_pkg::PAT_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [prs_pkg::BYTE_W-1:0]    in_byte = '0;
  logic                          end_of_stream = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [prs_pkg::BYTE_W-1:0]    out_byte;
  logic                          is_replacement;
  logic                          last_out;

  // Predictor state: register copies and the pending window.
  logic [prs_pkg::PAT_W-1:0]  pat_r = '0;
  logic [prs_pkg::PLEN_W-1:0] plen_r = 4'd1;
  logic [prs_pkg::BYTE_W-1:0] repl_r = '0;
  logic [prs_pkg::BYTE_W-1:0] win_bytes [0:prs_pkg::MAX_PATTERN-1];
  int                         win_fill = 0;

  result_t expected_results [$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      rx_burst_left = 0;
  int      rx_hold_left = 0;
  bit      rx_hold_start = 1'b0;
  bit      tx_offering = 1'b0;

  pattern_replace_stream u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .end_of_stream  (end_of_stream),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .is_replacement (is_replacement),
    .last_out       (last_out)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rx_hold_start) begin
      rx_hold_start = 1'b0;
      rx_hold_left  = RX_HOLD_CYCLES;
    end
    if (rst) begin
      out_stall     <= 1'b0;
      rx_burst_left <= 0;
    end else if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else if (rx_burst_left > 0) begin
      out_stall     <= 1'b1;
      rx_burst_left <= rx_burst_left - 1;
    end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      out_stall     <= 1'b1;
      rx_burst_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every output transfer must match the oldest predicted byte.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected output: byte %h rep %0d last %0d",
                   out_byte, is_replacement, last_out);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_byte !== exp_r.data || is_replacement !== exp_r.rep ||
            last_out !== exp_r.last) begin
          if (mismatch_count < 10)
            $display("mismatch: byte exp %h got %h, rep exp %0d got %0d, last exp %0d got %0d",
                     exp_r.data, out_byte, exp_r.rep, is_replacement,
                     exp_r.last, last_out);
          mismatch_count++;
        end
      end
    end
  end

  // A length of zero acts as one, anything above the window size as the maximum.
  function automatic int active_length();
    if (plen_r == 0) return 1;
    if (plen_r > prs_pkg::MAX_PATTERN) return prs_pkg::MAX_PATTERN;
    return int'(plen_r);
  endfunction

  task automatic predict_replace(input logic [prs_pkg::BYTE_W-1:0] b, input logic eos);
    int      len;
    int      produced;
    bit      hit;
    result_t r;
    len      = active_length();
    produced = 0;
    if (win_fill >= len) win_fill = 0;
    win_bytes[win_fill] = b;
    win_fill++;
    if (win_fill == len) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++)
        if (win_bytes[i] != pat_r[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        r = '{repl_r, 1'b1, 1'b0};
        win_fill = 0;
      end else begin
        r = '{win_bytes[0], 1'b0, 1'b0};
        for (int i = 1; i < len; i++) win_bytes[i-1] = win_bytes[i];
        win_fill = len - 1;
      end
      expected_results.push_back(r);
      produced++;
    end
    if (eos) begin
      for (int i = 0; i < win_fill; i++) begin
        r = '{win_bytes[i], 1'b0, 1'b0};
        expected_results.push_back(r);
        produced++;
      end
      win_fill = 0;
      if (produced > 0) expected_results[expected_results.size()-1].last = 1'b1;
    end
  endtask

  task automatic send_byte(input logic [prs_pkg::BYTE_W-1:0] b, input logic eos);
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_stream <= eos;
    tx_offering = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_replace(b, eos);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      tx_offering = 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Sends up to eight bytes, first byte in bits 7:0.
  task automatic send_packed(input logic [63:0] bytes, input int n, input bit close);
    for (int i = 0; i < n; i++) send_byte(bytes[8*i +: 8], close && i == n - 1);
  endtask

  // Waits for every predicted byte, then lets a possible flush finish.
  task automatic settle();
    if (tx_offering) begin
      in_valid <= 1'b0;
      tx_offering = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input prs_pkg::cfg_reg_t idx,
                           input logic [prs_pkg::PAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      prs_pkg::REG_PATTERN: pat_r = data;
      prs_pkg::REG_LENGTH: begin
        plen_r   = data[prs_pkg::PLEN_W-1:0];
        win_fill = 0;
      end
      prs_pkg::REG_REPLACE: repl_r = data[prs_pkg::BYTE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [prs_pkg::PAT_W-1:0] pat,
                           input logic [prs_pkg::PLEN_W-1:0] len,
                           input logic [prs_pkg::BYTE_W-1:0] repl);
    settle();
    write_reg(prs_pkg::REG_PATTERN, pat);
    // Upper bits of the data word are ignored by the length and replacement registers.
    write_reg(prs_pkg::REG_LENGTH, {$urandom, 28'($urandom), len});
    write_reg(prs_pkg::REG_REPLACE, {$urandom, 24'($urandom), repl});
    cfg_valid <= 1'b0;
  endtask

  // Streams built mostly from whole or broken copies of the pattern.
  task automatic run_streams(input int target, input bit may_cut);
    int                         len;
    int                         stream_len;
    int                         k;
    int                         sent;
    logic [prs_pkg::BYTE_W-1:0] b;
    logic [prs_pkg::BYTE_W-1:0] seq [$];
    bit                         close_it;
    sent = 0;
    while (sent < target) begin
      len = active_length();
      stream_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
      seq.delete();
      while (seq.size() < stream_len) begin
        k = $urandom_range(0, 9);
        if (k < 5) begin
          for (int i = 0; i < len; i++) seq.push_back(pat_r[8*i +: 8]);
        end else if (k < 7) begin
          k = $urandom_range(1, len);
          for (int i = 0; i < k - 1; i++) seq.push_back(pat_r[8*i +: 8]);
          b = pat_r[8*(k-1) +: 8] ^ 8'($urandom_range(1, 255));
          seq.push_back(b);
        end else begin
          b = 8'($urandom);
          seq.push_back(b);
        end
      end
      // Now and then the final stream of a phase is left open.
      close_it = !(may_cut && sent + stream_len >= target && $urandom_range(0, 3) == 0);
      for (int i = 0; i < stream_len; i++) send_byte(seq[i], close_it && i == stream_len - 1);
      sent += stream_len;
    end
  endtask

  // Reset values: pattern byte zero, length one, replacement zero.
  task automatic test_reset_values();
    send_packed(64'h5A_FF_00, 3, 1'b1);
  endtask

  // Zero bytes inside the pattern must compare like any other byte.
  task automatic test_zero_byte_pattern();
    configure(64'h0000_0000_0042_0041, 4'd3, 8'hA5);
    send_packed(64'h00_42_43_00_41_42_00_41, 7, 1'b1);
  endtask

  // Length above the window acts as the maximum; one byte yields eight outputs.
  task automatic test_longest_flush();
    configure('1, 4'd15, 8'h00);
    send_packed(64'hFE_FF_FF_FF_FF_FF_FF_FF, 8, 1'b1);
    send_packed(64'hFF, 1, 1'b1);
  endtask

  task automatic test_zero_length();
    configure(64'h33, 4'd0, 8'hCC);
    send_packed(64'h33_32_33, 3, 1'b1);
  endtask

  // A length write while bytes are pending drops them.
  task automatic test_length_write_drops_window();
    configure(64'h4433_2211, 4'd4, 8'h99);
    send_packed(64'h22_11, 2, 1'b0);
    settle();
    write_reg(prs_pkg::REG_LENGTH, 64'd3);
    cfg_valid <= 1'b0;
    send_packed(64'h33_22_11, 3, 1'b1);
  endtask

  task automatic test_random_streams();
    logic [prs_pkg::PAT_W-1:0]  pat;
    logic [prs_pkg::PLEN_W-1:0] len;
    logic [prs_pkg::BYTE_W-1:0] repl;
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      tx_idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 10 : 40);
      rx_idle_pct = (phase % 4 == 1) ? 0 : ((phase % 4 == 2) ? 40 : 10);
      pat  = (phase == 0) ? '0 : ((phase == 1) ? '1 : {$urandom, $urandom});
      repl = (phase == 0) ? 8'hFF : ((phase == 1) ? 8'h00 : 8'($urandom));
      case (phase)
        2: len = 4'd1;
        3: len = 4'd8;
        4: len = 4'd0;
        5: len = 4'($urandom_range(9, 15));
        default: len = 4'($urandom_range(1, 8));
      endcase
      configure(pat, len, repl);
      run_streams(28, 1'b1);
    end
  endtask

  // Output held off long enough that the block must stall its input.
  task automatic test_backpressure();
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure({$urandom, $urandom}, 4'd1, 8'($urandom));
    rx_hold_start = 1'b1;
    run_streams(30, 1'b0);
  endtask

  task automatic test_steady_tail();
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure({$urandom, $urandom}, 4'($urandom_range(1, 8)), 8'($urandom));
    run_streams(40, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < prs_pkg::MAX_PATTERN; i++) win_bytes[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_zero_byte_pattern();
    test_longest_flush();
    test_zero_length();
    test_length_write_drops_window();
    test_random_streams();
    test_backpressure();
    test_steady_tail();
    settle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
